// ----- hw/rtl/sts_pkg.sv -----
// sts_pkg: token codes, error codes, scan modes and keyword table for the
// source token scanner. No dependencies.

package sts_pkg;

   localparam int TOKEN_W = 6;
   localparam int ERROR_W = 3;
   localparam int LINE_W  = 16;
   localparam int LEN_W   = 16;
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int MAX_RESULTS = 3;

   // input item kinds
   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LAST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

   // token types
   localparam logic [TOKEN_W-1:0] TT_LPAREN        = 6'd0;
   localparam logic [TOKEN_W-1:0] TT_RPAREN        = 6'd1;
   localparam logic [TOKEN_W-1:0] TT_LBRACE        = 6'd2;
   localparam logic [TOKEN_W-1:0] TT_RBRACE        = 6'd3;
   localparam logic [TOKEN_W-1:0] TT_SEMICOLON     = 6'd4;
   localparam logic [TOKEN_W-1:0] TT_COMMA         = 6'd5;
   localparam logic [TOKEN_W-1:0] TT_DOT           = 6'd6;
   localparam logic [TOKEN_W-1:0] TT_MINUS         = 6'd7;
   localparam logic [TOKEN_W-1:0] TT_PLUS          = 6'd8;
   localparam logic [TOKEN_W-1:0] TT_STAR          = 6'd9;
   localparam logic [TOKEN_W-1:0] TT_SLASH         = 6'd10;
   localparam logic [TOKEN_W-1:0] TT_BANG          = 6'd11;
   localparam logic [TOKEN_W-1:0] TT_BANG_EQUAL    = 6'd12;
   localparam logic [TOKEN_W-1:0] TT_EQUAL         = 6'd13;
   localparam logic [TOKEN_W-1:0] TT_EQUAL_EQUAL   = 6'd14;
   localparam logic [TOKEN_W-1:0] TT_LESS          = 6'd15;
   localparam logic [TOKEN_W-1:0] TT_LESS_EQUAL    = 6'd16;
   localparam logic [TOKEN_W-1:0] TT_GREATER       = 6'd17;
   localparam logic [TOKEN_W-1:0] TT_GREATER_EQUAL = 6'd18;
   localparam logic [TOKEN_W-1:0] TT_AND           = 6'd19;
   localparam logic [TOKEN_W-1:0] TT_OR            = 6'd20;
   localparam logic [TOKEN_W-1:0] TT_INTEGER       = 6'd21;
   localparam logic [TOKEN_W-1:0] TT_FLOAT         = 6'd22;
   localparam logic [TOKEN_W-1:0] TT_CHAR          = 6'd23;
   localparam logic [TOKEN_W-1:0] TT_STRING        = 6'd24;
   localparam logic [TOKEN_W-1:0] TT_IDENT         = 6'd25;
   localparam logic [TOKEN_W-1:0] TT_KW0           = 6'd26;
   localparam logic [TOKEN_W-1:0] TT_EOF           = 6'd37;
   localparam logic [TOKEN_W-1:0] TT_ERROR         = 6'd38;

   // error kinds
   localparam logic [ERROR_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [ERROR_W-1:0] ERR_LONE_AMP    = 3'd1;
   localparam logic [ERROR_W-1:0] ERR_LONE_PIPE   = 3'd2;
   localparam logic [ERROR_W-1:0] ERR_UNEXPECTED  = 3'd3;
   localparam logic [ERROR_W-1:0] ERR_BAD_ESCAPE  = 3'd4;
   localparam logic [ERROR_W-1:0] ERR_OPEN_CHAR   = 3'd5;
   localparam logic [ERROR_W-1:0] ERR_OPEN_STRING = 3'd6;

   typedef enum logic [4:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_BANG,
      MODE_EQ,
      MODE_LT,
      MODE_GT,
      MODE_AMP,
      MODE_PIPE,
      MODE_INT,
      MODE_FRAC,
      MODE_IDENT,
      MODE_CH_OPEN,
      MODE_CH_ESC,
      MODE_CH_CLOSE,
      MODE_STR
   } mode_type;

   // keywords, left aligned: first character in the top byte
   localparam int KW_COUNT   = 11;
   localparam int KW_MAX_LEN = 6;

   localparam logic [KW_MAX_LEN-1:0][7:0] KW_TEXT [KW_COUNT] = '{
      {"class", 8'h00},
      {"else", 16'h0000},
      {"false", 8'h00},
      {"for", 24'h000000},
      {"if", 32'h00000000},
      "return",
      {"super", 8'h00},
      {"this", 16'h0000},
      {"true", 16'h0000},
      {"var", 24'h000000},
      {"while", 8'h00}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

   typedef struct packed {
      logic                 vld;
      logic [TOKEN_W-1:0]   ttype;
      logic [ERROR_W-1:0]   err;
      logic [LEN_W-1:0]     len;
      logic [LINE_W-1:0]    line;
   } tok_type;

endpackage

// ----- hw/rtl/source_token_scanner.sv -----
// source_token_scanner: streaming scanner from source bytes to tokens.
// Depends on sts_pkg for token codes, scan modes and the keyword table.
//
// A byte is taken per cycle if items yield at most one token and rsp_tready is
// high. Each item is held in an input register, scanned by one pass of logic
// against the scan state, and its tokens (zero to three) leave through a
// registered output one per cycle while not stalled; a new item is accepted in
// the cycle the previous one hands over its last token. The output register
// decouples the sides: the next item is taken while a token still waits for
// rsp_tready. Kind 1 closes the input after the byte, kind 2 (or 3) closes it
// without a byte; both end with an EoF token. last marks an item's last token.

module source_token_scanner #(
   parameter int KEYWORD_CHARS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_req
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // line [15:0], token_length [31:16]
   output logic [8:0]  rsp_tuser,   // token_type [5:0], error_kind [8:6]
   output logic        rsp_tlast    // last_of_run
);

   localparam int IDW = $clog2(KEYWORD_CHARS + 1);
   localparam int IXW = $clog2(KEYWORD_CHARS);

   localparam logic [sts_pkg::LEN_W-1:0]  LEN_MAX  = '1;
   localparam logic [sts_pkg::LINE_W-1:0] LINE_MAX = '1;

   function automatic logic [sts_pkg::LEN_W-1:0] len_inc(
      input logic [sts_pkg::LEN_W-1:0] v);
      return (v == LEN_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [sts_pkg::LINE_W-1:0] line_inc(
      input logic [sts_pkg::LINE_W-1:0] v);
      return (v == LINE_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [sts_pkg::TOKEN_W-1:0] ident_kind(
      input logic [sts_pkg::KW_MAX_LEN-1:0][7:0] chars,
      input logic [sts_pkg::LEN_W-1:0]           len);
      logic [sts_pkg::TOKEN_W-1:0] t;
      logic                        hit;
      t = sts_pkg::TT_IDENT;
      for (int i = sts_pkg::KW_COUNT - 1; i >= 0; i--) begin
         hit = (len == sts_pkg::LEN_W'(sts_pkg::KW_LEN[i]));
         for (int j = 0; j < sts_pkg::KW_MAX_LEN; j++) begin
            if ((j < int'(sts_pkg::KW_LEN[i])) &&
                (chars[j] != sts_pkg::KW_TEXT[i][sts_pkg::KW_MAX_LEN-1-j])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            t = sts_pkg::TT_KW0 + sts_pkg::TOKEN_W'(i);
         end
      end
      return t;
   endfunction

   function automatic sts_pkg::tok_type make_tok(
      input logic [sts_pkg::TOKEN_W-1:0] ttype,
      input logic [sts_pkg::ERROR_W-1:0] err,
      input logic [sts_pkg::LEN_W-1:0]   len);
      sts_pkg::tok_type t;
      t.vld   = 1'b1;
      t.ttype = ttype;
      t.err   = err;
      t.len   = len;
      t.line  = '0;
      return t;
   endfunction

   // scan state
   sts_pkg::mode_type                mode_ff, mode_in;
   logic [sts_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [sts_pkg::LINE_W-1:0]       line_ff, line_in;
   logic [IDW-1:0]                   idl_ff, idl_in;
   logic [KEYWORD_CHARS-1:0][7:0]    kw_ff, kw_in;

   // input register
   logic                             item_vld_ff, item_vld_in;
   logic [sts_pkg::KIND_W-1:0]       kind_ff;
   logic [sts_pkg::BYTE_W-1:0]       byte_ff;
   logic [1:0]                       idx_ff, idx_in;

   // output register
   logic                             rsp_vld_ff, rsp_vld_in;
   sts_pkg::tok_type                 rsp_tok_ff;
   logic                             rsp_last_ff;

   sts_pkg::tok_type                 cand [4];
   sts_pkg::tok_type                 res [sts_pkg::MAX_RESULTS];
   logic [1:0]                       res_n;
   logic                             rescan;
   logic                             has_byte;
   logic                             closing;
   logic [sts_pkg::BYTE_W-1:0]       c;
   logic [sts_pkg::TOKEN_W-1:0]      op_tok;
   logic                             out_free;
   logic                             step;
   logic                             done;

   // scan of one item
   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      idl_in   = idl_ff;
      kw_in    = kw_ff;
      rescan   = 1'b0;
      op_tok   = sts_pkg::TT_GREATER;
      c        = byte_ff;
      has_byte = !kind_ff[1];
      closing  = (kind_ff != sts_pkg::KIND_BYTE);
      for (int i = 0; i < 4; i++) begin
         cand[i] = '0;
      end

      // pending token
      if (has_byte) begin
         case (mode_ff)
            sts_pkg::MODE_IDLE: begin
               rescan = 1'b1;
            end
            sts_pkg::MODE_SLASH: begin
               if (c == "/") begin
                  mode_in = sts_pkg::MODE_COMMENT;
               end else begin
                  cand[0] = make_tok(sts_pkg::TT_SLASH, sts_pkg::ERR_NONE, 16'd1);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_COMMENT: begin
               if (c == 8'h0A) begin
                  line_in = line_inc(line_ff);
                  mode_in = sts_pkg::MODE_IDLE;
               end
            end
            sts_pkg::MODE_BANG, sts_pkg::MODE_EQ, sts_pkg::MODE_LT, sts_pkg::MODE_GT: begin
               case (mode_ff)
                  sts_pkg::MODE_BANG: begin
                     op_tok = (c == "=") ? sts_pkg::TT_BANG_EQUAL : sts_pkg::TT_BANG;
                  end
                  sts_pkg::MODE_EQ: begin
                     op_tok = (c == "=") ? sts_pkg::TT_EQUAL_EQUAL : sts_pkg::TT_EQUAL;
                  end
                  sts_pkg::MODE_LT: begin
                     op_tok = (c == "=") ? sts_pkg::TT_LESS_EQUAL : sts_pkg::TT_LESS;
                  end
                  default: begin
                     op_tok = (c == "=") ? sts_pkg::TT_GREATER_EQUAL : sts_pkg::TT_GREATER;
                  end
               endcase
               if (c == "=") begin
                  cand[0] = make_tok(op_tok, sts_pkg::ERR_NONE, 16'd2);
                  mode_in = sts_pkg::MODE_IDLE;
               end else begin
                  cand[0] = make_tok(op_tok, sts_pkg::ERR_NONE, 16'd1);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_AMP: begin
               if (c == "&") begin
                  cand[0] = make_tok(sts_pkg::TT_AND, sts_pkg::ERR_NONE, 16'd2);
                  mode_in = sts_pkg::MODE_IDLE;
               end else begin
                  cand[0] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_AMP, 16'd0);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_PIPE: begin
               if (c == "|") begin
                  cand[0] = make_tok(sts_pkg::TT_OR, sts_pkg::ERR_NONE, 16'd2);
                  mode_in = sts_pkg::MODE_IDLE;
               end else begin
                  cand[0] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_PIPE, 16'd0);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_INT: begin
               if (c inside {["0":"9"]}) begin
                  len_in = len_inc(len_ff);
               end else if (c == ".") begin
                  len_in  = len_inc(len_ff);
                  mode_in = sts_pkg::MODE_FRAC;
               end else begin
                  cand[0] = make_tok(sts_pkg::TT_INTEGER, sts_pkg::ERR_NONE, len_ff);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_FRAC: begin
               if (c inside {["0":"9"]}) begin
                  len_in = len_inc(len_ff);
               end else begin
                  cand[0] = make_tok(sts_pkg::TT_FLOAT, sts_pkg::ERR_NONE, len_ff);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_IDENT: begin
               if (c inside {["0":"9"], ["a":"z"], ["A":"Z"], "_"}) begin
                  len_in = len_inc(len_ff);
                  if (idl_ff < IDW'(KEYWORD_CHARS)) begin
                     kw_in[idl_ff[IXW-1:0]] = c;
                     idl_in = idl_ff + 1'b1;
                  end
               end else begin
                  cand[0] = make_tok(ident_kind(kw_ff[sts_pkg::KW_MAX_LEN-1:0], len_ff),
                                     sts_pkg::ERR_NONE, len_ff);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_CH_OPEN: begin
               len_in  = len_inc(len_ff);
               mode_in = (c == "\\") ? sts_pkg::MODE_CH_ESC : sts_pkg::MODE_CH_CLOSE;
            end
            sts_pkg::MODE_CH_ESC: begin
               if (c inside {"\\", "n", "r", "0", "'", "\""}) begin
                  len_in  = len_inc(len_ff);
                  mode_in = sts_pkg::MODE_CH_CLOSE;
               end else begin
                  cand[0] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_BAD_ESCAPE, 16'd0);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_CH_CLOSE: begin
               if (c == "'") begin
                  len_in  = len_inc(len_ff);
                  cand[0] = make_tok(sts_pkg::TT_CHAR, sts_pkg::ERR_NONE, len_in);
                  mode_in = sts_pkg::MODE_IDLE;
               end else begin
                  cand[0] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_OPEN_CHAR, 16'd0);
                  rescan  = 1'b1;
               end
            end
            sts_pkg::MODE_STR: begin
               len_in = len_inc(len_ff);
               if (c == 8'h0A) begin
                  line_in = line_inc(line_ff);
               end
               if (c == "\"") begin
                  cand[0] = make_tok(sts_pkg::TT_STRING, sts_pkg::ERR_NONE, len_in);
                  mode_in = sts_pkg::MODE_IDLE;
               end
            end
            default: begin
               rescan = 1'b1;
            end
         endcase
      end

      // byte seen from idle
      if (rescan) begin
         mode_in = sts_pkg::MODE_IDLE;
         if (c inside {["0":"9"]}) begin
            mode_in = sts_pkg::MODE_INT;
            len_in  = 16'd1;
         end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
            mode_in  = sts_pkg::MODE_IDENT;
            len_in   = 16'd1;
            kw_in[0] = c;
            idl_in   = IDW'(1);
         end else begin
            case (c)
               8'h20, 8'h0D, 8'h09: begin
               end
               8'h0A: line_in = line_inc(line_ff);
               "(": cand[1] = make_tok(sts_pkg::TT_LPAREN, sts_pkg::ERR_NONE, 16'd1);
               ")": cand[1] = make_tok(sts_pkg::TT_RPAREN, sts_pkg::ERR_NONE, 16'd1);
               "{": cand[1] = make_tok(sts_pkg::TT_LBRACE, sts_pkg::ERR_NONE, 16'd1);
               "}": cand[1] = make_tok(sts_pkg::TT_RBRACE, sts_pkg::ERR_NONE, 16'd1);
               ";": cand[1] = make_tok(sts_pkg::TT_SEMICOLON, sts_pkg::ERR_NONE, 16'd1);
               ",": cand[1] = make_tok(sts_pkg::TT_COMMA, sts_pkg::ERR_NONE, 16'd1);
               ".": cand[1] = make_tok(sts_pkg::TT_DOT, sts_pkg::ERR_NONE, 16'd1);
               "-": cand[1] = make_tok(sts_pkg::TT_MINUS, sts_pkg::ERR_NONE, 16'd1);
               "+": cand[1] = make_tok(sts_pkg::TT_PLUS, sts_pkg::ERR_NONE, 16'd1);
               "*": cand[1] = make_tok(sts_pkg::TT_STAR, sts_pkg::ERR_NONE, 16'd1);
               "/": begin
                  mode_in = sts_pkg::MODE_SLASH;
                  len_in  = 16'd1;
               end
               "!": begin
                  mode_in = sts_pkg::MODE_BANG;
                  len_in  = 16'd1;
               end
               "=": begin
                  mode_in = sts_pkg::MODE_EQ;
                  len_in  = 16'd1;
               end
               "<": begin
                  mode_in = sts_pkg::MODE_LT;
                  len_in  = 16'd1;
               end
               ">": begin
                  mode_in = sts_pkg::MODE_GT;
                  len_in  = 16'd1;
               end
               "&": begin
                  mode_in = sts_pkg::MODE_AMP;
                  len_in  = 16'd1;
               end
               "|": begin
                  mode_in = sts_pkg::MODE_PIPE;
                  len_in  = 16'd1;
               end
               "'": begin
                  mode_in = sts_pkg::MODE_CH_OPEN;
                  len_in  = 16'd1;
               end
               "\"": begin
                  mode_in = sts_pkg::MODE_STR;
                  len_in  = 16'd1;
               end
               default: cand[1] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_UNEXPECTED, 16'd0);
            endcase
         end
      end

      // end of input closes what is pending
      if (closing) begin
         case (mode_in)
            sts_pkg::MODE_SLASH:
               cand[2] = make_tok(sts_pkg::TT_SLASH, sts_pkg::ERR_NONE, 16'd1);
            sts_pkg::MODE_BANG:
               cand[2] = make_tok(sts_pkg::TT_BANG, sts_pkg::ERR_NONE, 16'd1);
            sts_pkg::MODE_EQ:
               cand[2] = make_tok(sts_pkg::TT_EQUAL, sts_pkg::ERR_NONE, 16'd1);
            sts_pkg::MODE_LT:
               cand[2] = make_tok(sts_pkg::TT_LESS, sts_pkg::ERR_NONE, 16'd1);
            sts_pkg::MODE_GT:
               cand[2] = make_tok(sts_pkg::TT_GREATER, sts_pkg::ERR_NONE, 16'd1);
            sts_pkg::MODE_AMP:
               cand[2] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_AMP, 16'd0);
            sts_pkg::MODE_PIPE:
               cand[2] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_PIPE, 16'd0);
            sts_pkg::MODE_INT:
               cand[2] = make_tok(sts_pkg::TT_INTEGER, sts_pkg::ERR_NONE, len_in);
            sts_pkg::MODE_FRAC:
               cand[2] = make_tok(sts_pkg::TT_FLOAT, sts_pkg::ERR_NONE, len_in);
            sts_pkg::MODE_IDENT:
               cand[2] = make_tok(ident_kind(kw_in[sts_pkg::KW_MAX_LEN-1:0], len_in),
                                  sts_pkg::ERR_NONE, len_in);
            sts_pkg::MODE_CH_OPEN, sts_pkg::MODE_CH_CLOSE:
               cand[2] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_OPEN_CHAR, 16'd0);
            sts_pkg::MODE_CH_ESC:
               cand[2] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_BAD_ESCAPE, 16'd0);
            sts_pkg::MODE_STR:
               cand[2] = make_tok(sts_pkg::TT_ERROR, sts_pkg::ERR_OPEN_STRING, 16'd0);
            default: begin
            end
         endcase
         cand[3] = make_tok(sts_pkg::TT_EOF, sts_pkg::ERR_NONE, 16'd0);
         mode_in = sts_pkg::MODE_IDLE;
      end

      cand[0].line = line_ff;
      cand[1].line = line_ff;
      cand[2].line = line_in;
      cand[3].line = line_in;
   end

   // compact to at most three results
   always_comb begin
      res_n = 2'd0;
      for (int i = 0; i < sts_pkg::MAX_RESULTS; i++) begin
         res[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         if (cand[i].vld && (res_n != 2'd3)) begin
            res[res_n] = cand[i];
            res_n      = res_n + 2'd1;
         end
      end
   end

   // handshake and sequencing
   always_comb begin
      out_free    = !rsp_vld_ff || rsp_tready;
      step        = item_vld_ff && ((res_n == 2'd0) || out_free);
      done        = step && ((res_n == 2'd0) || (idx_ff == res_n - 2'd1));
      req_tready  = !item_vld_ff || done;
      item_vld_in = req_tvalid ? 1'b1 : (item_vld_ff && !done);
      idx_in      = done ? 2'd0 : (step ? idx_ff + 2'd1 : idx_ff);
      rsp_vld_in  = (step && (res_n != 2'd0)) ? 1'b1 : (rsp_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sts_pkg::MODE_IDLE;
         len_ff      <= '0;
         line_ff     <= 16'd1;
         idl_ff      <= '0;
         item_vld_ff <= 1'b0;
         idx_ff      <= 2'd0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (done) begin
            mode_ff <= mode_in;
            len_ff  <= len_in;
            line_ff <= line_in;
            idl_ff  <= idl_in;
         end
         if (req_tready) begin
            item_vld_ff <= item_vld_in;
         end
         idx_ff     <= idx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         kw_ff <= kw_in;
      end
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser;
         byte_ff <= req_tdata;
      end
      if (step && (res_n != 2'd0)) begin
         rsp_tok_ff  <= res[idx_ff];
         rsp_last_ff <= (idx_ff == res_n - 2'd1);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_tok_ff.len, rsp_tok_ff.line};
   assign rsp_tuser  = {rsp_tok_ff.err, rsp_tok_ff.ttype};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- test/source_token_scanner_tb.sv -----
// source_token_scanner_tb: drives source bytes into the token scanner and checks every
// token against a scanner model kept here; directed, random and stall tests.
// Depends on sts_pkg and source_token_scanner.
`timescale 1ns / 1ps

module source_token_scanner_tb;

   localparam int KW_CHARS      = 6;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 230;

   localparam logic [sts_pkg::KIND_W-1:0] KIND_END_ALT = 2'd3;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int READY_ALWAYS  = 0;
   localparam int READY_RANDOM  = 1;
   localparam int READY_PATTERN = 2;

   typedef struct packed {
      logic [sts_pkg::TOKEN_W-1:0] ttype;
      logic [sts_pkg::ERROR_W-1:0] err;
      logic [sts_pkg::LINE_W-1:0]  line;
      logic [sts_pkg::LEN_W-1:0]   len;
      logic                        last;
   } token_rec_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // byte_req
   logic [1:0]  req_tuser  = 2'd0;    // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // line [15:0], token_length [31:16]
   logic [8:0]  rsp_tuser;            // token_type [5:0], error_kind [8:6]
   logic        rsp_tlast;            // last_of_run

   source_token_scanner #(.KEYWORD_CHARS(KW_CHARS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scanner model state
   sts_pkg::mode_type scan_state   = sts_pkg::MODE_IDLE;
   logic [7:0]        kw_prefix [KW_CHARS];
   int                prefix_count = 0;
   logic [15:0]       line_no      = 16'd1;
   logic [15:0]       tok_len      = 16'd0;
   token_rec_type     step_tokens[$];
   token_rec_type     expected_tokens[$];

   string keyword_text [11] = '{"class", "else", "false", "for", "if", "return",
                                "super", "this", "true", "var", "while"};
   string op_text [12] = '{"!", "!=", "=", "==", "<", "<=", ">", ">=", "&&", "||", "&", "|"};
   string punct_chars = "(){};,.-+*/";
   string ident_head  = "abcdefghijklmnopqrstuvwxyzACFILRSTVW_";
   string ident_body  = "abcdefghijklmnopqrstuvwxyzACFILRSTVW_0123456789";
   string digit_chars = "0123456789";
   string blank_chars = " \t\015\n";
   string esc_chars   = "\\nr0'\"";

   logic [7:0] text_q[$];
   int  error_count  = 0;
   int  items_sent   = 0;
   int  burst_left   = 0;
   bit  gaps_enabled = 1'b1;
   bit  offering     = 1'b0;
   bit  hold_request = 1'b0;
   int  stall_cycles = 0;

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void put_token(logic [sts_pkg::TOKEN_W-1:0] tt,
                                     logic [sts_pkg::ERROR_W-1:0] ek,
                                     logic [sts_pkg::LEN_W-1:0] len);
      token_rec_type t;
      if (step_tokens.size() < sts_pkg::MAX_RESULTS) begin
         t.ttype = tt;
         t.err   = ek;
         t.line  = line_no;
         t.len   = len;
         t.last  = 1'b0;
         step_tokens.push_back(t);
      end
   endfunction

   function automatic void grow_token();
      if (tok_len != 16'hFFFF) tok_len++;
   endfunction

   function automatic void next_line();
      if (line_no != 16'hFFFF) line_no++;
   endfunction

   function automatic void keep_prefix(logic [7:0] c);
      if (prefix_count < KW_CHARS) begin
         kw_prefix[prefix_count] = c;
         prefix_count++;
      end
   endfunction

   function automatic void open_token(sts_pkg::mode_type m);
      scan_state = m;
      tok_len = 16'd1;
   endfunction

   function automatic logic [sts_pkg::TOKEN_W-1:0] word_type();
      bit same;
      if (tok_len > KW_CHARS) return sts_pkg::TT_IDENT;
      for (int i = 0; i < 11; i++) begin
         if (tok_len == keyword_text[i].len() && keyword_text[i].len() <= prefix_count) begin
            same = 1'b1;
            for (int j = 0; j < keyword_text[i].len(); j++)
               if (kw_prefix[j] != keyword_text[i][j]) same = 1'b0;
            if (same) return sts_pkg::TT_KW0 + sts_pkg::TOKEN_W'(i);
         end
      end
      return sts_pkg::TT_IDENT;
   endfunction

   function automatic logic [sts_pkg::TOKEN_W-1:0] short_op(sts_pkg::mode_type m);
      case (m)
         sts_pkg::MODE_BANG: return sts_pkg::TT_BANG;
         sts_pkg::MODE_EQ:   return sts_pkg::TT_EQUAL;
         sts_pkg::MODE_LT:   return sts_pkg::TT_LESS;
         default:            return sts_pkg::TT_GREATER;
      endcase
   endfunction

   function automatic void scan_start(logic [7:0] c);
      if (is_digit(c)) open_token(sts_pkg::MODE_INT);
      else if (is_alpha(c)) begin
         open_token(sts_pkg::MODE_IDENT);
         prefix_count = 0;
         keep_prefix(c);
      end else begin
         case (c)
            CH_SPACE, CH_CR, CH_TAB: ;
            CH_NL: next_line();
            "(": put_token(sts_pkg::TT_LPAREN, sts_pkg::ERR_NONE, 16'd1);
            ")": put_token(sts_pkg::TT_RPAREN, sts_pkg::ERR_NONE, 16'd1);
            "{": put_token(sts_pkg::TT_LBRACE, sts_pkg::ERR_NONE, 16'd1);
            "}": put_token(sts_pkg::TT_RBRACE, sts_pkg::ERR_NONE, 16'd1);
            ";": put_token(sts_pkg::TT_SEMICOLON, sts_pkg::ERR_NONE, 16'd1);
            ",": put_token(sts_pkg::TT_COMMA, sts_pkg::ERR_NONE, 16'd1);
            ".": put_token(sts_pkg::TT_DOT, sts_pkg::ERR_NONE, 16'd1);
            "-": put_token(sts_pkg::TT_MINUS, sts_pkg::ERR_NONE, 16'd1);
            "+": put_token(sts_pkg::TT_PLUS, sts_pkg::ERR_NONE, 16'd1);
            "*": put_token(sts_pkg::TT_STAR, sts_pkg::ERR_NONE, 16'd1);
            "/": open_token(sts_pkg::MODE_SLASH);
            "!": open_token(sts_pkg::MODE_BANG);
            "=": open_token(sts_pkg::MODE_EQ);
            "<": open_token(sts_pkg::MODE_LT);
            ">": open_token(sts_pkg::MODE_GT);
            "&": open_token(sts_pkg::MODE_AMP);
            "|": open_token(sts_pkg::MODE_PIPE);
            "'": open_token(sts_pkg::MODE_CH_OPEN);
            "\"": open_token(sts_pkg::MODE_STR);
            default: put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_UNEXPECTED, 16'd0);
         endcase
      end
   endfunction

   // a byte that ends a pending token is scanned again from idle
   function automatic void scan_byte(logic [7:0] c);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (scan_state)
            sts_pkg::MODE_IDLE: scan_start(c);
            sts_pkg::MODE_SLASH:
               if (c == "/") scan_state = sts_pkg::MODE_COMMENT;
               else begin
                  put_token(sts_pkg::TT_SLASH, sts_pkg::ERR_NONE, 16'd1);
                  again = 1'b1;
               end
            sts_pkg::MODE_COMMENT:
               if (c == CH_NL) begin
                  next_line();
                  scan_state = sts_pkg::MODE_IDLE;
               end
            sts_pkg::MODE_BANG, sts_pkg::MODE_EQ, sts_pkg::MODE_LT, sts_pkg::MODE_GT:
               if (c == "=") begin
                  put_token(short_op(scan_state) + 1'b1, sts_pkg::ERR_NONE, 16'd2);
                  scan_state = sts_pkg::MODE_IDLE;
               end else begin
                  put_token(short_op(scan_state), sts_pkg::ERR_NONE, 16'd1);
                  again = 1'b1;
               end
            sts_pkg::MODE_AMP:
               if (c == "&") begin
                  put_token(sts_pkg::TT_AND, sts_pkg::ERR_NONE, 16'd2);
                  scan_state = sts_pkg::MODE_IDLE;
               end else begin
                  put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_AMP, 16'd0);
                  again = 1'b1;
               end
            sts_pkg::MODE_PIPE:
               if (c == "|") begin
                  put_token(sts_pkg::TT_OR, sts_pkg::ERR_NONE, 16'd2);
                  scan_state = sts_pkg::MODE_IDLE;
               end else begin
                  put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_PIPE, 16'd0);
                  again = 1'b1;
               end
            sts_pkg::MODE_INT:
               if (is_digit(c)) grow_token();
               else if (c == ".") begin
                  grow_token();
                  scan_state = sts_pkg::MODE_FRAC;
               end else begin
                  put_token(sts_pkg::TT_INTEGER, sts_pkg::ERR_NONE, tok_len);
                  again = 1'b1;
               end
            sts_pkg::MODE_FRAC:
               if (is_digit(c)) grow_token();
               else begin
                  put_token(sts_pkg::TT_FLOAT, sts_pkg::ERR_NONE, tok_len);
                  again = 1'b1;
               end
            sts_pkg::MODE_IDENT:
               if (is_alpha(c) || is_digit(c)) begin
                  grow_token();
                  keep_prefix(c);
               end else begin
                  put_token(word_type(), sts_pkg::ERR_NONE, tok_len);
                  again = 1'b1;
               end
            sts_pkg::MODE_CH_OPEN: begin
               grow_token();
               if (c == "\\") scan_state = sts_pkg::MODE_CH_ESC;
               else scan_state = sts_pkg::MODE_CH_CLOSE;
            end
            sts_pkg::MODE_CH_ESC:
               if (c == "\\" || c == "n" || c == "r" || c == "0" || c == "'" || c == "\"") begin
                  grow_token();
                  scan_state = sts_pkg::MODE_CH_CLOSE;
               end else begin
                  put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_BAD_ESCAPE, 16'd0);
                  again = 1'b1;
               end
            sts_pkg::MODE_CH_CLOSE:
               if (c == "'") begin
                  grow_token();
                  put_token(sts_pkg::TT_CHAR, sts_pkg::ERR_NONE, tok_len);
                  scan_state = sts_pkg::MODE_IDLE;
               end else begin
                  put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_OPEN_CHAR, 16'd0);
                  again = 1'b1;
               end
            sts_pkg::MODE_STR: begin
               grow_token();
               if (c == CH_NL) next_line();
               if (c == "\"") begin
                  put_token(sts_pkg::TT_STRING, sts_pkg::ERR_NONE, tok_len);
                  scan_state = sts_pkg::MODE_IDLE;
               end
            end
            default: ;
         endcase
         if (again) scan_state = sts_pkg::MODE_IDLE;
      end
   endfunction

   function automatic void close_input();
      case (scan_state)
         sts_pkg::MODE_SLASH: put_token(sts_pkg::TT_SLASH, sts_pkg::ERR_NONE, 16'd1);
         sts_pkg::MODE_BANG, sts_pkg::MODE_EQ, sts_pkg::MODE_LT, sts_pkg::MODE_GT:
            put_token(short_op(scan_state), sts_pkg::ERR_NONE, 16'd1);
         sts_pkg::MODE_AMP: put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_AMP, 16'd0);
         sts_pkg::MODE_PIPE: put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_LONE_PIPE, 16'd0);
         sts_pkg::MODE_INT: put_token(sts_pkg::TT_INTEGER, sts_pkg::ERR_NONE, tok_len);
         sts_pkg::MODE_FRAC: put_token(sts_pkg::TT_FLOAT, sts_pkg::ERR_NONE, tok_len);
         sts_pkg::MODE_IDENT: put_token(word_type(), sts_pkg::ERR_NONE, tok_len);
         sts_pkg::MODE_CH_OPEN, sts_pkg::MODE_CH_CLOSE:
            put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_OPEN_CHAR, 16'd0);
         sts_pkg::MODE_CH_ESC: put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_BAD_ESCAPE, 16'd0);
         sts_pkg::MODE_STR: put_token(sts_pkg::TT_ERROR, sts_pkg::ERR_OPEN_STRING, 16'd0);
         default: ;
      endcase
      scan_state = sts_pkg::MODE_IDLE;
      put_token(sts_pkg::TT_EOF, sts_pkg::ERR_NONE, 16'd0);
   endfunction

   function automatic void predict_tokens(logic [sts_pkg::KIND_W-1:0] kind, logic [7:0] c);
      step_tokens.delete();
      if (kind == sts_pkg::KIND_BYTE || kind == sts_pkg::KIND_LAST) scan_byte(c);
      if (kind != sts_pkg::KIND_BYTE) close_input();
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   function automatic logic [7:0] pick_char(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   // mostly well formed lexemes, with noise bytes and broken literals mixed in
   function automatic void add_random_lexeme();
      int n;
      case ($urandom_range(0, 10))
         0: text_q.push_back(pick_char(punct_chars));
         1: push_text(op_text[$urandom_range(0, 11)]);
         2: repeat ($urandom_range(1, 4)) text_q.push_back(pick_char(digit_chars));
         3: begin
            repeat ($urandom_range(1, 3)) text_q.push_back(pick_char(digit_chars));
            text_q.push_back(".");
            repeat ($urandom_range(0, 3)) text_q.push_back(pick_char(digit_chars));
         end
         4: begin
            text_q.push_back(pick_char(ident_head));
            repeat ($urandom_range(0, 8)) text_q.push_back(pick_char(ident_body));
         end
         5: begin
            push_text(keyword_text[$urandom_range(0, 10)]);
            if ($urandom_range(0, 3) == 0) text_q.push_back(pick_char(ident_body));
         end
         6: begin
            text_q.push_back("'");
            n = $urandom_range(0, 3);
            if (n == 0) text_q.push_back(8'($urandom_range(0, 255)));
            else if (n == 1) begin
               text_q.push_back("\\");
               text_q.push_back(pick_char(esc_chars));
            end else if (n == 2) begin
               text_q.push_back("\\");
               text_q.push_back(8'($urandom_range(0, 255)));
            end else text_q.push_back(pick_char(ident_body));
            if ($urandom_range(0, 4) != 0) text_q.push_back("'");
         end
         7: begin
            text_q.push_back("\"");
            repeat ($urandom_range(0, 6))
               text_q.push_back(($urandom_range(0, 5) == 0) ? CH_NL :
                                8'($urandom_range(32, 126)));
            if ($urandom_range(0, 9) != 0) text_q.push_back("\"");
         end
         8: begin
            push_text("//");
            repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(32, 126)));
            text_q.push_back(CH_NL);
         end
         9: text_q.push_back(pick_char(blank_chars));
         default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1) == 1) text_q.push_back(pick_char(blank_chars));
   endfunction

   task automatic send_item(input logic [sts_pkg::KIND_W-1:0] kind, input logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= b;
      offering = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_tokens(kind, b);
      items_sent++;
      if (burst_left > 0) burst_left--;
      else if (gaps_enabled) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(sts_pkg::KIND_BYTE, s[i]);
   endtask

   task automatic send_source(input bit close_run);
      logic [sts_pkg::KIND_W-1:0] k = sts_pkg::KIND_BYTE;
      for (int i = 0; i < text_q.size(); i++) begin
         k = sts_pkg::KIND_BYTE;
         if (close_run && i == text_q.size() - 1 && $urandom_range(0, 1) == 1)
            k = sts_pkg::KIND_LAST;
         send_item(k, text_q[i]);
      end
      if (close_run && k == sts_pkg::KIND_BYTE)
         send_item(($urandom_range(0, 1) == 1) ? sts_pkg::KIND_END : KIND_END_ALT,
                   8'($urandom_range(0, 255)));
   endtask

   task automatic wait_for_results();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_edge_cases();
      send_text("1..'\\q 'ab");
      send_item(sts_pkg::KIND_BYTE, 8'h00);
      send_item(sts_pkg::KIND_BYTE, 8'hFF);
      send_item(sts_pkg::KIND_BYTE, "_");
      send_item(sts_pkg::KIND_LAST, "a");
      send_item(KIND_END_ALT, 8'hA5);
      send_item(sts_pkg::KIND_BYTE, "&");
      send_item(sts_pkg::KIND_END, 8'($urandom_range(0, 255)));
      send_item(sts_pkg::KIND_BYTE, "'");
      send_item(sts_pkg::KIND_END, 8'($urandom_range(0, 255)));
      send_item(sts_pkg::KIND_BYTE, "'");
      send_item(sts_pkg::KIND_BYTE, "\\");
      send_item(sts_pkg::KIND_END, 8'($urandom_range(0, 255)));
      send_item(sts_pkg::KIND_BYTE, "\"");
      send_item(sts_pkg::KIND_LAST, "x");
      wait_for_results();
   endtask

   task automatic test_random_source();
      int stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         text_q.delete();
         repeat ($urandom_range(1, 6)) add_random_lexeme();
         send_source($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   // the receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_output_stall();
      hold_request = 1'b1;
      gaps_enabled = 1'b0;
      text_q.delete();
      repeat (14) add_random_lexeme();
      send_source(1'b1);
      gaps_enabled = 1'b1;
      wait_for_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_random_source();
      test_output_stall();
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // receiver: stretches of always ready, random stalls and a fixed pattern
   int hold_left = 0, stretch_left = 0, ready_style = READY_ALWAYS, beat = 0;
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            ready_style  = $urandom_range(READY_ALWAYS, READY_PATTERN);
            stretch_left = $urandom_range(16, 96);
         end
         stretch_left--;
         beat++;
         case (ready_style)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_RANDOM: rsp_tready <= ($urandom_range(0, 1) == 1);
            default:      rsp_tready <= (beat % 5 >= 2);
         endcase
      end
   end

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      token_rec_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            error_count++;
            $error("token_type %0d arrived with no token expected", rsp_tuser[5:0]);
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_type", 16'(want.ttype), 16'(rsp_tuser[5:0]));
            check_field("error_kind", 16'(want.err), 16'(rsp_tuser[8:6]));
            check_field("line", want.line, rsp_tdata[15:0]);
            check_field("token_length", want.len, rsp_tdata[31:16]);
            check_field("last_of_run", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
